// ----- rtl/obsf_pkg.sv -----
// Shared types, constants and state codes of the order book sweep fill block.
`timescale 1ns / 1ps

package obsf_pkg;

    // Fixed-point quantity width and default fraction bits
    localparam int QTY_W         = 64;
    localparam int HALF_W        = QTY_W / 2;
    localparam int PROD_W        = 2 * QTY_W;
    localparam int FRAC_BITS_DEF = 24;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH   = 2;

    typedef logic [QTY_W-1:0] qty_t;

    // Input beat: one book level
    typedef struct packed {
        logic side;
        logic first_level;
        logic last_level;
        logic level_present;
        qty_t start_amount;
        qty_t level_price;
        qty_t level_volume;
    } obsf_in_t;

    // Result beat: one finished sweep
    typedef struct packed {
        qty_t received_amount;
        qty_t next_level_price;
        logic next_price_valid;
        logic fully_filled;
        logic zero_price_error;
        logic saturated;
    } obsf_out_t;

    // Queue entry: level plus what the front worked out about it
    typedef struct packed {
        obsf_in_t item;
        logic     price_zero;
    } obsf_entry_t;

    // Divider request and response
    typedef struct packed {
        logic start;
        qty_t dividend;
        qty_t divisor;
    } obsf_div_req_t;

    typedef struct packed {
        logic done;
        logic sat;
        qty_t quotient;
    } obsf_div_rsp_t;

    // Back end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEVEL,
        ST_MUL,
        ST_APPLY,
        ST_DIV,
        ST_EMIT
    } obsf_state_t;

endpackage

// ----- rtl/order_book_sweep_fill.sv -----
// Top level of the order book sweep fill block.
//
// Usage: stream one side of a book on s_*, one level per beat, best level
// first. first_level loads start_amount and the side; last_level closes the
// sweep and one result beat follows on m_*. Beats with no level, no start
// and no end are dropped at the front.
// Flow: the front stage and a two-entry queue pass each beat on; the back end
// takes one beat at a time, through IDLE, LEVEL and EMIT for a beat with no
// level to work, and through MUL and APPLY as well for a level (a 64x64
// product built from four 32x32 partial products). An ask level that
// completes the fill also waits in DIV on the bit-serial divider. Levels
// after the fill go through IDLE, LEVEL and EMIT only.
// Reset (aresetn low, synchronous) empties the queue, drops any pending
// result and clears the sweep state to zero.
// Stall: a result waits in the output register while m_ready is low; the
// front keeps accepting until the queue fills, and the back end holds only
// when it has a second result ready.
`timescale 1ns / 1ps

module order_book_sweep_fill
    import obsf_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  obsf_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output obsf_out_t m_data
);

    logic          push_valid, push_ready;
    obsf_entry_t   push_entry;
    logic          pop_valid, pop_ready;
    obsf_entry_t   pop_entry;
    obsf_div_req_t div_req;
    obsf_div_rsp_t div_rsp;

    obsf_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    obsf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    obsf_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .div_req (div_req),
        .div_rsp (div_rsp)
    );

    obsf_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_entry (pop_entry),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// ----- rtl/obsf_front.sv -----
// Front end: accepts input beats, drops beats that do nothing, tags zero prices.
`timescale 1ns / 1ps

module obsf_front
    import obsf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  obsf_in_t    s_data,
    output logic        push_valid,
    input  logic        push_ready,
    output obsf_entry_t push_entry
);

    logic        hold_valid_reg, hold_valid_next;
    obsf_entry_t hold_reg;
    logic        accept;
    logic        useful;

    assign s_ready    = !hold_valid_reg || push_ready;
    assign accept     = s_valid && s_ready;
    assign push_valid = hold_valid_reg;
    assign push_entry = hold_reg;

    // A beat with no level, no start and no end leaves the state as it is
    assign useful = s_data.first_level || s_data.level_present || s_data.last_level;

    always_comb begin
        hold_valid_next = hold_valid_reg;
        if (accept) begin
            hold_valid_next = useful;
        end else if (push_ready) begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    // Payload stage, no reset
    always_ff @(posedge aclk) begin
        if (accept) begin
            hold_reg.item       <= s_data;
            hold_reg.price_zero <= (s_data.level_price == '0);
        end
    end

endmodule

// ----- rtl/obsf_queue.sv -----
// Short queue of classified levels between the front and back ends.
`timescale 1ns / 1ps

module obsf_queue
    import obsf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push_valid,
    output logic        push_ready,
    input  obsf_entry_t push_entry,
    output logic        pop_valid,
    input  logic        pop_ready,
    output obsf_entry_t pop_entry
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    obsf_entry_t      slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer wrap and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ----- rtl/obsf_div.sv -----
// Radix-2 restoring divider: floor((q << FRAC_BITS) / d), saturating, one bit a cycle.
`timescale 1ns / 1ps

module obsf_div
    import obsf_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  obsf_div_req_t div_req,
    output obsf_div_rsp_t div_rsp
);

    localparam int CNT_W = $clog2(QTY_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic             sat_reg, sat_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    qty_t             rem_reg, rem_next;
    qty_t             lo_reg, lo_next;
    qty_t             quo_reg, quo_next;
    qty_t             init_rem;
    logic [QTY_W:0]   wide_rem;
    logic [QTY_W:0]   wide_diff;

    assign init_rem  = div_req.dividend >> (QTY_W - FRAC_BITS);
    assign wide_rem  = {rem_reg, lo_reg[QTY_W-1]};
    assign wide_diff = wide_rem - {1'b0, div_req.divisor};

    assign div_rsp.done     = done_reg;
    assign div_rsp.sat      = sat_reg;
    assign div_rsp.quotient = quo_reg;

    // Load, overflow check, then one quotient bit per cycle
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        sat_next  = sat_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        lo_next   = lo_reg;
        quo_next  = quo_reg;
        if (busy_reg) begin
            // wide_rem carries the shifted-out bit, so a set top bit also subtracts
            if (!wide_diff[QTY_W] || wide_rem[QTY_W]) begin
                rem_next = wide_diff[QTY_W-1:0];
                quo_next = {quo_reg[QTY_W-2:0], 1'b1};
            end else begin
                rem_next = wide_rem[QTY_W-1:0];
                quo_next = {quo_reg[QTY_W-2:0], 1'b0};
            end
            lo_next  = {lo_reg[QTY_W-2:0], 1'b0};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(QTY_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (div_req.start) begin
            if (init_rem >= div_req.divisor) begin
                quo_next  = '1;
                sat_next  = 1'b1;
                done_next = 1'b1;
            end else begin
                rem_next  = init_rem;
                lo_next   = div_req.dividend << FRAC_BITS;
                quo_next  = '0;
                sat_next  = 1'b0;
                cnt_next  = '0;
                busy_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        sat_reg <= sat_next;
        rem_reg <= rem_next;
        lo_reg  <= lo_next;
        quo_reg <= quo_next;
    end

endmodule

// ----- rtl/obsf_back.sv -----
// Back end: sweep state, sequenced 64x64 multiply, fill bookkeeping and result register.
`timescale 1ns / 1ps

module obsf_back
    import obsf_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          pop_valid,
    output logic          pop_ready,
    input  obsf_entry_t   pop_entry,
    output obsf_div_req_t div_req,
    input  obsf_div_rsp_t div_rsp,
    output logic          m_valid,
    input  logic          m_ready,
    output obsf_out_t     m_data
);

    localparam int MUL_STEPS = 4;
    localparam int MCNT_W    = $clog2(MUL_STEPS + 1);

    // Saturating add: top bit of the result flags overflow
    function automatic logic [QTY_W:0] sat_add(qty_t a, qty_t b);
        logic [QTY_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s[QTY_W]) begin
            return {1'b1, {QTY_W{1'b1}}};
        end
        return s;
    endfunction

    obsf_state_t       state_reg, state_next;
    obsf_entry_t       cur_reg, cur_next;
    qty_t              rem_reg, rem_next;
    qty_t              rec_reg, rec_next;
    logic              fill_reg, fill_next;
    logic              stop_reg, stop_next;
    qty_t              cap_price_reg, cap_price_next;
    logic              cap_valid_reg, cap_valid_next;
    logic              side_reg, side_next;
    logic              err_zero_reg, err_zero_next;
    logic              err_sat_reg, err_sat_next;
    logic              bid_full_reg, bid_full_next;
    qty_t              mul_a_reg, mul_a_next;
    qty_t              mul_b_reg, mul_b_next;
    logic [MCNT_W-1:0] mul_cnt_reg, mul_cnt_next;
    logic [QTY_W-1:0]  pp_reg, pp_next;
    logic [PROD_W-1:0] acc_reg, acc_next;
    logic              out_valid_reg, out_valid_next;
    obsf_out_t         out_reg, out_next;

    logic [HALF_W-1:0] a_half, b_half;
    logic [PROD_W-1:0] pp_shifted;
    logic [PROD_W-1:0] prod_shift;
    logic              mul_sat;
    qty_t              mul_res;
    logic [QTY_W:0]    add_mul, add_vol, add_quo;
    logic              out_free;
    logic              ask_done;

    assign pop_ready = (state_reg == ST_IDLE);
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;
    assign out_free  = !out_valid_reg || m_ready;

    // Partial product select: ll, lh, hl, hh
    assign a_half = mul_cnt_reg[1] ? mul_a_reg[QTY_W-1:HALF_W] : mul_a_reg[HALF_W-1:0];
    assign b_half = mul_cnt_reg[0] ? mul_b_reg[QTY_W-1:HALF_W] : mul_b_reg[HALF_W-1:0];
    assign pp_next = QTY_W'(a_half) * QTY_W'(b_half);

    // Weight of the partial product captured in the previous step
    always_comb begin
        case (mul_cnt_reg)
            MCNT_W'(1): pp_shifted = PROD_W'(pp_reg);
            MCNT_W'(2),
            MCNT_W'(3): pp_shifted = PROD_W'(pp_reg) << HALF_W;
            MCNT_W'(4): pp_shifted = PROD_W'(pp_reg) << QTY_W;
            default:    pp_shifted = '0;
        endcase
    end

    // Truncate by the fraction bits, saturate when the top does not fit
    assign prod_shift = acc_reg >> FRAC_BITS;
    assign mul_sat    = |prod_shift[PROD_W-1:QTY_W];
    assign mul_res    = mul_sat ? '1 : prod_shift[QTY_W-1:0];

    assign add_mul = sat_add(rec_reg, mul_res);
    assign add_vol = sat_add(rec_reg, cur_reg.item.level_volume);
    assign add_quo = sat_add(rec_reg, div_rsp.quotient);

    // Ask level that uses up the quote and needs the divider
    assign ask_done = (state_reg == ST_APPLY) && side_reg && (rem_reg <= mul_res)
                      && !cur_reg.price_zero;

    assign div_req.start    = ask_done;
    assign div_req.dividend = rem_reg;
    assign div_req.divisor  = cur_reg.item.level_price;

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        rem_next       = rem_reg;
        rec_next       = rec_reg;
        fill_next      = fill_reg;
        stop_next      = stop_reg;
        cap_price_next = cap_price_reg;
        cap_valid_next = cap_valid_reg;
        side_next      = side_reg;
        err_zero_next  = err_zero_reg;
        err_sat_next   = err_sat_reg;
        bid_full_next  = bid_full_reg;
        mul_a_next     = mul_a_reg;
        mul_b_next     = mul_b_reg;
        mul_cnt_next   = mul_cnt_reg;
        acc_next       = acc_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_ready;

        case (state_reg)
            ST_IDLE: begin
                if (pop_valid) begin
                    cur_next = pop_entry;
                    if (pop_entry.item.first_level) begin
                        rem_next       = pop_entry.item.start_amount;
                        rec_next       = '0;
                        fill_next      = 1'b0;
                        stop_next      = 1'b0;
                        cap_price_next = '0;
                        cap_valid_next = 1'b0;
                        side_next      = pop_entry.item.side;
                        err_zero_next  = 1'b0;
                        err_sat_next   = 1'b0;
                    end
                    state_next = ST_LEVEL;
                end
            end

            ST_LEVEL: begin
                state_next = ST_EMIT;
                if (cur_reg.item.level_present && !stop_reg) begin
                    cap_price_next = cur_reg.item.level_price;
                    cap_valid_next = 1'b1;
                    if (fill_reg) begin
                        // Price after the fill is captured; the sweep ends here
                        stop_next = 1'b1;
                    end else begin
                        if (!side_reg) begin
                            bid_full_next = (rem_reg <= cur_reg.item.level_volume);
                            mul_a_next    = (rem_reg <= cur_reg.item.level_volume)
                                            ? rem_reg : cur_reg.item.level_volume;
                            mul_b_next    = cur_reg.item.level_price;
                        end else begin
                            mul_a_next = cur_reg.item.level_price;
                            mul_b_next = cur_reg.item.level_volume;
                        end
                        mul_cnt_next = '0;
                        acc_next     = '0;
                        state_next   = ST_MUL;
                    end
                end
            end

            ST_MUL: begin
                acc_next     = acc_reg + pp_shifted;
                mul_cnt_next = mul_cnt_reg + MCNT_W'(1);
                if (mul_cnt_reg == MCNT_W'(MUL_STEPS)) begin
                    state_next = ST_APPLY;
                end
            end

            ST_APPLY: begin
                state_next   = ST_EMIT;
                err_sat_next = err_sat_reg | mul_sat;
                if (!side_reg) begin
                    // Bid: quote received for the base sold at this level
                    rec_next     = add_mul[QTY_W-1:0];
                    err_sat_next = err_sat_reg | mul_sat | add_mul[QTY_W];
                    if (bid_full_reg) begin
                        rem_next  = '0;
                        fill_next = 1'b1;
                    end else begin
                        rem_next = rem_reg - cur_reg.item.level_volume;
                    end
                end else if (rem_reg <= mul_res) begin
                    // Ask: this level covers the rest of the quote
                    if (cur_reg.price_zero) begin
                        err_zero_next = 1'b1;
                        rem_next      = '0;
                        fill_next     = 1'b1;
                    end else begin
                        state_next = ST_DIV;
                    end
                end else begin
                    // Ask: whole level bought
                    rec_next     = add_vol[QTY_W-1:0];
                    err_sat_next = err_sat_reg | mul_sat | add_vol[QTY_W];
                    rem_next     = rem_reg - mul_res;
                end
            end

            ST_DIV: begin
                if (div_rsp.done) begin
                    rec_next     = add_quo[QTY_W-1:0];
                    err_sat_next = err_sat_reg | div_rsp.sat | add_quo[QTY_W];
                    rem_next     = '0;
                    fill_next    = 1'b1;
                    state_next   = ST_EMIT;
                end
            end

            ST_EMIT: begin
                if (!cur_reg.item.last_level) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    out_next.received_amount  = err_zero_reg ? '0 : rec_reg;
                    out_next.next_level_price = cap_price_reg;
                    out_next.next_price_valid = cap_valid_reg;
                    out_next.fully_filled     = fill_reg;
                    out_next.zero_price_error = err_zero_reg;
                    out_next.saturated        = err_sat_reg;
                    out_valid_next            = 1'b1;
                    stop_next                 = 1'b1;
                    state_next                = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and sweep state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            rem_reg       <= '0;
            rec_reg       <= '0;
            fill_reg      <= 1'b0;
            stop_reg      <= 1'b0;
            cap_price_reg <= '0;
            cap_valid_reg <= 1'b0;
            side_reg      <= 1'b0;
            err_zero_reg  <= 1'b0;
            err_sat_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            mul_cnt_reg   <= '0;
        end else begin
            state_reg     <= state_next;
            rem_reg       <= rem_next;
            rec_reg       <= rec_next;
            fill_reg      <= fill_next;
            stop_reg      <= stop_next;
            cap_price_reg <= cap_price_next;
            cap_valid_reg <= cap_valid_next;
            side_reg      <= side_next;
            err_zero_reg  <= err_zero_next;
            err_sat_reg   <= err_sat_next;
            out_valid_reg <= out_valid_next;
            mul_cnt_reg   <= mul_cnt_next;
        end
    end

    // Datapath registers, no reset
    always_ff @(posedge aclk) begin
        cur_reg      <= cur_next;
        bid_full_reg <= bid_full_next;
        mul_a_reg    <= mul_a_next;
        mul_b_reg    <= mul_b_next;
        pp_reg       <= pp_next;
        acc_reg      <= acc_next;
        out_reg      <= out_next;
    end

endmodule

// ----- rtl/obsf_check.sv -----
// Port-level checker for the order book sweep fill block, with its bind.
`timescale 1ns / 1ps

module obsf_check
    import obsf_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      m_valid,
    input logic      m_ready,
    input obsf_out_t m_data
);

    // Result beat holds while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_data))
        else $error("result beat changed while stalled");

    // Zero price error reports no amount
    a_zero_amount: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.zero_price_error |-> m_data.received_amount == '0)
        else $error("amount reported with zero price error");

    // Zero price error only arises on the completing level
    a_zero_filled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.zero_price_error |-> m_data.fully_filled)
        else $error("zero price error without a completed fill");

    // Empty book reports a zero price
    a_empty_price: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.next_price_valid |-> m_data.next_level_price == '0)
        else $error("price reported for an empty book");

endmodule

bind order_book_sweep_fill obsf_check u_obsf_check (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ----- sim/tb.sv -----
// Self-checking testbench for the order book sweep fill block.
`timescale 1ns / 1ps

module tb;
    import obsf_pkg::*;

    localparam int   FRAC         = FRAC_BITS_DEF;
    localparam qty_t UNIT         = 64'd1 << FRAC;
    localparam qty_t QMAX         = {QTY_W{1'b1}};
    localparam int   ITEM_TARGET  = 1350;
    localparam int   HOLD_AT      = 400;
    localparam int   DRAIN_AT     = 800;
    localparam int   CALM_AT      = 1150;
    localparam int   HOLD_CYCLES  = 300;
    localparam int   DRAIN_CYCLES = 100;
    localparam int   STALL_LIMIT  = 2000;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    obsf_in_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    obsf_out_t m_data;

    // Directed stimulus row: a level beat, optionally with its result typed in
    typedef struct {
        obsf_in_t  beat;
        bit        typed;
        obsf_out_t fill;
    } dir_row_t;

    dir_row_t  dir_tab[$];
    obsf_out_t fill_q[$];

    // Predicted sweep state
    qty_t rem_amt    = '0;
    qty_t recv_total = '0;
    bit   filled     = 1'b0;
    bit   stopped    = 1'b0;
    qty_t cap_price  = '0;
    bit   cap_valid  = 1'b0;
    bit   ask_side   = 1'b0;
    bit   zero_err   = 1'b0;
    bit   sat_err    = 1'b0;

    int errors      = 0;
    int beats_sent  = 0;
    int n_fills     = 0;
    int n_complete  = 0;
    int n_zero      = 0;
    int n_sat       = 0;
    bit idle_on     = 1'b1;
    bit hold_req    = 1'b0;
    int hold_left   = 0;
    int stall_left  = 0;

    always #2 aclk = ~aclk;

    order_book_sweep_fill #(
        .FRAC_BITS(FRAC)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Fixed-point helpers: exact product/quotient, truncated, saturating
    function automatic qty_t fixed_mul(input qty_t a, input qty_t b, output bit ovf);
        logic [PROD_W-1:0] p;
        p = {64'd0, a} * {64'd0, b};
        ovf = (p >> (QTY_W + FRAC)) != 0;
        p = p >> FRAC;
        return ovf ? QMAX : p[QTY_W-1:0];
    endfunction

    function automatic qty_t fixed_div(input qty_t q, input qty_t d, output bit ovf);
        logic [PROD_W-1:0] n;
        ovf = (q >> (QTY_W - FRAC)) >= d;
        n = ({64'd0, q} << FRAC) / {64'd0, d};
        return ovf ? QMAX : n[QTY_W-1:0];
    endfunction

    function automatic qty_t add_sat(input qty_t a, input qty_t b, output bit ovf);
        logic [QTY_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        ovf = s[QTY_W];
        return ovf ? QMAX : s[QTY_W-1:0];
    endfunction

    // Advance the predicted sweep by one level beat; returns the fill on last_level
    task automatic sweep_step(input obsf_in_t b, output bit emits, output obsf_out_t r);
        qty_t part;
        qty_t cost;
        bit   o1;
        bit   o2;
        bit   sat;
        emits = 1'b0;
        r     = '0;
        sat   = 1'b0;
        o1    = 1'b0;
        o2    = 1'b0;
        if (b.first_level) begin
            rem_amt    = b.start_amount;
            recv_total = '0;
            filled     = 1'b0;
            stopped    = 1'b0;
            cap_price  = '0;
            cap_valid  = 1'b0;
            ask_side   = b.side;
            zero_err   = 1'b0;
            sat_err    = 1'b0;
        end
        if (b.level_present && !stopped) begin
            cap_price = b.level_price;
            cap_valid = 1'b1;
            if (filled) begin
                stopped = 1'b1;
            end else if (!ask_side) begin
                // bid: sell base, receive price * volume
                if (rem_amt <= b.level_volume) begin
                    part = fixed_mul(rem_amt, b.level_price, o1);
                    recv_total = add_sat(recv_total, part, o2);
                    rem_amt = '0;
                    filled  = 1'b1;
                end else begin
                    part = fixed_mul(b.level_volume, b.level_price, o1);
                    recv_total = add_sat(recv_total, part, o2);
                    rem_amt = rem_amt - b.level_volume;
                end
            end else begin
                // ask: spend quote, the completing level divides by its price
                cost = fixed_mul(b.level_price, b.level_volume, o1);
                sat  = o1;
                o1   = 1'b0;
                if (rem_amt <= cost) begin
                    if (b.level_price != 0) begin
                        part = fixed_div(rem_amt, b.level_price, o1);
                        recv_total = add_sat(recv_total, part, o2);
                    end else begin
                        zero_err = 1'b1;
                    end
                    rem_amt = '0;
                    filled  = 1'b1;
                end else begin
                    recv_total = add_sat(recv_total, b.level_volume, o2);
                    rem_amt = rem_amt - cost;
                end
            end
            if (sat || o1 || o2)
                sat_err = 1'b1;
        end
        if (b.last_level) begin
            emits = 1'b1;
            r.received_amount  = zero_err ? '0 : recv_total;
            r.next_level_price = cap_price;
            r.next_price_valid = cap_valid;
            r.fully_filled     = filled;
            r.zero_price_error = zero_err;
            r.saturated        = sat_err;
            stopped = 1'b1;
        end
    endtask

    function automatic obsf_in_t lvl(input bit sd, input bit fl, input bit ll, input bit lp,
                                     input qty_t st, input qty_t pr, input qty_t vo);
        obsf_in_t b;
        b.side          = sd;
        b.first_level   = fl;
        b.last_level    = ll;
        b.level_present = lp;
        b.start_amount  = st;
        b.level_price   = pr;
        b.level_volume  = vo;
        return b;
    endfunction

    function automatic obsf_out_t outcome(input qty_t amt, input qty_t nxt, input bit nv,
                                          input bit ff, input bit ze, input bit st);
        obsf_out_t r;
        r.received_amount  = amt;
        r.next_level_price = nxt;
        r.next_price_valid = nv;
        r.fully_filled     = ff;
        r.zero_price_error = ze;
        r.saturated        = st;
        return r;
    endfunction

    task automatic add_row(input obsf_in_t b, input bit typed, input obsf_out_t r);
        dir_row_t row;
        row.beat  = b;
        row.typed = typed;
        row.fill  = r;
        dir_tab = {dir_tab, row};
    endtask

    // Random quantities: mostly realistic magnitudes, some extremes and raw bits
    function automatic qty_t plausible_qty();
        return (qty_t'($urandom_range(0, 999)) << FRAC)
               | qty_t'($urandom_range(0, (1 << FRAC) - 1));
    endfunction

    function automatic qty_t rnd_qty();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return QMAX;
            2, 3:    return {$urandom, $urandom};
            default: return plausible_qty();
        endcase
    endfunction

    function automatic qty_t rnd_start(input bit ask);
        bit o;
        if ($urandom_range(0, 9) == 0)
            return rnd_qty();
        if (ask)
            return fixed_mul(plausible_qty(), plausible_qty(), o)
                   * qty_t'($urandom_range(1, 4));
        return plausible_qty() * qty_t'($urandom_range(1, 4));
    endfunction

    function automatic obsf_in_t noise_beat();
        return lvl(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   rnd_qty(), rnd_qty(), rnd_qty());
    endfunction

    // Offer one level beat, wait for the handshake, then log the expected fill
    task automatic put_beat(input obsf_in_t b, input bit typed, input obsf_out_t r);
        obsf_out_t pred;
        obsf_out_t want;
        bit        emits;
        if (idle_on && $urandom_range(0, 9) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        do @(posedge aclk); while (!s_ready);
        sweep_step(b, emits, pred);
        if (emits) begin
            want   = typed ? r : pred;
            fill_q = {fill_q, want};
        end
        if (b.first_level || b.last_level || b.level_present)
            beats_sent++;
    endtask

    // One sweep of a book side with random content; now and then a broken one
    task automatic random_sweep();
        obsf_in_t b;
        bit       ask;
        int       n;
        int       flaw;
        ask  = 1'($urandom_range(0, 1));
        n    = $urandom_range(0, 6);
        flaw = $urandom_range(0, 19);
        for (int k = 0; k <= n; k++) begin
            b = noise_beat();
            b.first_level   = (k == 0) && (flaw != 0);
            b.last_level    = (k == n) && (flaw != 1);
            b.level_present = $urandom_range(0, 9) != 0;
            if (k == 0) begin
                b.side         = ask;
                b.start_amount = rnd_start(ask);
            end
            put_beat(b, 1'b0, '0);
        end
    endtask

    task automatic cmp_field(input string nm, input logic [63:0] e, input logic [63:0] a);
        if (e !== a) begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, nm, e, a);
            errors++;
        end
    endtask

    // Result side: check each fill beat, stall in bursts or on a hold request
    always @(posedge aclk) begin
        obsf_out_t e;
        if (aresetn && m_valid && m_ready) begin
            if (fill_q.size() == 0) begin
                $display("%0t ns: result beat with no expectation, expected none, actual %h",
                         $time, m_data);
                errors++;
            end else begin
                e = fill_q.pop_front();
                cmp_field("received_amount", e.received_amount, m_data.received_amount);
                cmp_field("next_level_price", e.next_level_price, m_data.next_level_price);
                cmp_field("next_price_valid", e.next_price_valid, m_data.next_price_valid);
                cmp_field("fully_filled", e.fully_filled, m_data.fully_filled);
                cmp_field("zero_price_error", e.zero_price_error, m_data.zero_price_error);
                cmp_field("saturated", e.saturated, m_data.saturated);
                n_fills++;
                n_complete += e.fully_filled;
                n_zero     += e.zero_price_error;
                n_sat      += e.saturated;
            end
        end
        if (hold_req && hold_left == 0) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 11) == 0) begin
            stall_left = $urandom_range(1, 18) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watchdog: too long with no beat moving on either side
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t ns: no beat accepted for %0d cycles", $time, STALL_LIMIT);
        $display("FAIL order_book_sweep_fill");
        $finish;
    end

    // Stimulus
    initial begin
        bit hold_done;
        bit drain_done;
        hold_done  = 1'b0;
        drain_done = 1'b0;

        // before any sweep: reset state, zero remaining on the bid side
        add_row(lvl(0, 0, 1, 1, '0, 3 * UNIT, 5 * UNIT), 1'b1,
                outcome('0, 3 * UNIT, 1, 1, 0, 0));
        // after a result the sweep is stopped; a new last_level repeats it
        add_row(lvl(1, 0, 1, 1, QMAX, 7 * UNIT, 7 * UNIT), 1'b1,
                outcome('0, 3 * UNIT, 1, 1, 0, 0));
        // empty book
        add_row(lvl(0, 1, 1, 0, 100 * UNIT, '0, '0), 1'b1, outcome('0, '0, 0, 0, 0, 0));
        // bid, one level fills
        add_row(lvl(0, 1, 1, 1, 2 * UNIT, 3 * UNIT, 5 * UNIT), 1'b1,
                outcome(6 * UNIT, 3 * UNIT, 1, 1, 0, 0));
        // zero start amount on ask
        add_row(lvl(1, 1, 1, 1, '0, 4 * UNIT, 9 * UNIT), 1'b1,
                outcome('0, 4 * UNIT, 1, 1, 0, 0));
        // ask completion at zero price
        add_row(lvl(1, 1, 1, 1, '0, '0, 5 * UNIT), 1'b1, outcome('0, '0, 1, 1, 1, 0));
        // ask partial level at zero price: volume comes free
        add_row(lvl(1, 1, 1, 1, 10 * UNIT, '0, 5 * UNIT), 1'b1,
                outcome(5 * UNIT, '0, 1, 0, 0, 0));
        // bid product saturates
        add_row(lvl(0, 1, 1, 1, QMAX, QMAX, QMAX), 1'b1, outcome(QMAX, QMAX, 1, 1, 0, 1));
        // ask cost saturates, quotient is exactly one
        add_row(lvl(1, 1, 1, 1, QMAX, QMAX, QMAX), 1'b1, outcome(UNIT, QMAX, 1, 1, 0, 1));
        // ask at the smallest price: full volume bought
        add_row(lvl(1, 1, 1, 1, QMAX, 64'd1, QMAX), 1'b1, outcome(QMAX, 64'd1, 1, 0, 0, 0));
        // bid sweep over three levels, capture, gap, ignored level
        add_row(lvl(0, 1, 0, 1, 10 * UNIT, 5 * UNIT, 4 * UNIT), 1'b0, '0);
        add_row(lvl(1, 0, 0, 1, QMAX, 4 * UNIT, '0), 1'b0, '0);
        add_row(lvl(0, 0, 0, 1, '0, '0, 3 * UNIT), 1'b0, '0);
        add_row(lvl(0, 0, 0, 1, '0, 3 * UNIT + 64'h5, 5 * UNIT), 1'b0, '0);
        add_row(lvl(0, 0, 0, 1, '0, 2 * UNIT, UNIT), 1'b0, '0);
        add_row(lvl(0, 0, 0, 0, '0, '0, '0), 1'b0, '0);
        add_row(lvl(0, 0, 1, 1, '0, UNIT, UNIT), 1'b0, '0);
        // ask sweep ending in a division, then the next price
        add_row(lvl(1, 1, 0, 1, 100 * UNIT, 2 * UNIT, 10 * UNIT), 1'b0, '0);
        add_row(lvl(0, 0, 0, 1, '0, 3 * UNIT, 10 * UNIT), 1'b0, '0);
        add_row(lvl(0, 0, 0, 1, '0, 7 * UNIT + 64'h3, 100 * UNIT), 1'b0, '0);
        add_row(lvl(0, 0, 1, 1, '0, 9 * UNIT, UNIT), 1'b0, '0);
        // exhausted book, then a restart in mid-sweep
        add_row(lvl(0, 1, 0, 1, 50 * UNIT, 5 * UNIT, UNIT), 1'b0, '0);
        add_row(lvl(0, 0, 1, 1, '0, 4 * UNIT, 2 * UNIT), 1'b0, '0);
        add_row(lvl(0, 1, 0, 1, 5 * UNIT, 2 * UNIT, UNIT), 1'b0, '0);
        add_row(lvl(1, 1, 1, 1, 30 * UNIT, 3 * UNIT, 2 * UNIT), 1'b0, '0);

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_tab[i])
            put_beat(dir_tab[i].beat, dir_tab[i].typed, dir_tab[i].fill);

        while (beats_sent < ITEM_TARGET) begin
            if (!hold_done && beats_sent >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_req  = 1'b1;
            end
            if (!drain_done && beats_sent >= DRAIN_AT) begin
                drain_done = 1'b1;
                s_valid <= 1'b0;
                @(posedge aclk);
                while (fill_q.size() != 0) @(posedge aclk);
            end
            if (beats_sent >= CALM_AT)
                idle_on = 1'b0;
            if ($urandom_range(0, 9) == 0)
                put_beat(noise_beat(), 1'b0, '0);
            else
                random_sweep();
        end
        s_valid <= 1'b0;

        // let the last results out, then watch for strays
        while (fill_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d level beats, checked %0d fills (%0d complete, %0d zero price, %0d saturated).",
                 beats_sent, n_fills, n_complete, n_zero, n_sat);
        $display("Bid and ask sweeps, empty and exhausted books, a long output hold, a full drain.");
        if (errors == 0 && fill_q.size() == 0) begin
            $display("PASS order_book_sweep_fill");
        end else begin
            $display("FAIL order_book_sweep_fill");
        end
        $finish;
    end

endmodule
